// File: rtl/countdown_task_scheduler_unit_assert.svh
// Assertion macros for the countdown task scheduler RTL.
// Included by the modules that check their own logic; no dependencies.
`ifndef COUNTDOWN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define COUNTDOWN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cts assertion failed (same cycle)");
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cts assertion failed (next cycle)");
`else
`define CTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/cts_pkg.sv
// Shared types and constants for the countdown task scheduler.
// No dependencies; used by the controller, datapath and top level.
package cts_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LEN_W = IDX_W + 1;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_RUN  = 2'd2;

	localparam logic signed [31:0] CD_FLOOR = 32'sh8000_0000;

	typedef struct packed {
		logic capture;
		logic add;
		logic tick;
		logic scan;
		logic fire;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic list_empty;
		logic scan_last;
	} dp_status_t;

endpackage

// File: rtl/cts_req_if.sv
// Request channel of the countdown task scheduler: valid/ready plus payload.
// Depends on nothing but plain logic types.
interface cts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [30:0] period;
	logic        repeat_req;

	modport source (output valid, output mode, output period, output repeat_req, input ready);
	modport sink (input valid, input mode, input period, input repeat_req, output ready);
endinterface

// File: rtl/cts_rsp_if.sv
// Response channel of the countdown task scheduler: valid/ready plus payload.
// Depends on nothing but plain logic types.
interface cts_rsp_if;
	logic        valid;
	logic        ready;
	logic        add_ok;
	logic [31:0] assigned_id;
	logic        fired;
	logic [31:0] fired_id;

	modport source (output valid, output add_ok, output assigned_id, output fired,
		output fired_id, input ready);
	modport sink (input valid, input add_ok, input assigned_id, input fired,
		input fired_id, output ready);
endinterface

// File: rtl/cts_ctrl.sv
// Controller state machine of the countdown task scheduler.
// Depends on cts_pkg and countdown_task_scheduler_unit_assert.svh.
`include "countdown_task_scheduler_unit_assert.svh"
module cts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          req_mode,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  cts_pkg::dp_status_t status,
	output cts_pkg::ctl_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_TICK = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_FIRE = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       req_fire;
	logic       load;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign load      = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = req_fire;
		cmd.add      = (state_q == ST_ADD);
		cmd.tick     = (state_q == ST_TICK);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.fire     = (state_q == ST_FIRE);
		cmd.load_out = load;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req_mode)
						cts_pkg::MODE_ADD:  state_d = ST_ADD;
						cts_pkg::MODE_TICK: state_d = ST_TICK;
						cts_pkg::MODE_RUN:  state_d = status.list_empty ? ST_DONE : ST_SCAN;
						default:            state_d = ST_DONE;
					endcase
				end
			end
			ST_ADD:  state_d = ST_DONE;
			ST_TICK: state_d = ST_DONE;
			ST_SCAN: begin
				if (status.scan_last) begin
					state_d = ST_FIRE;
				end
			end
			ST_FIRE: state_d = ST_DONE;
			ST_DONE: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`CTS_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_fire, state_q != ST_IDLE)
	`CTS_ASSERT_SAME(a_fire_after_scan, clk, arst_n, state_q == ST_FIRE, $past(state_q) == ST_SCAN)
	`CTS_ASSERT_NEXT(a_idle_after_load, clk, arst_n, load, rsp_valid_q && state_q == ST_IDLE)

endmodule

// File: rtl/cts_datapath.sv
// Datapath of the countdown task scheduler: slot table, list order, scan unit, results.
// Depends on cts_pkg and countdown_task_scheduler_unit_assert.svh.
`include "countdown_task_scheduler_unit_assert.svh"
module cts_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cts_pkg::ctl_cmd_t   cmd,
	output cts_pkg::dp_status_t status,
	input  logic [30:0]         period,
	input  logic                repeat_req,
	output logic                add_ok,
	output logic [31:0]         assigned_id,
	output logic                fired,
	output logic [31:0]         fired_id
);

	logic [cts_pkg::SLOTS-1:0]    valid_q;
	logic signed [31:0]           cd_q       [cts_pkg::SLOTS];
	logic [30:0]                  per_q      [cts_pkg::SLOTS];
	logic                         rep_q      [cts_pkg::SLOTS];
	logic [31:0]                  id_q       [cts_pkg::SLOTS];
	logic [cts_pkg::IDX_W-1:0]    order_q    [cts_pkg::SLOTS];
	logic [cts_pkg::LEN_W-1:0]    len_q;
	logic [31:0]                  next_id_q;
	logic [30:0]                  req_period_q;
	logic                         req_rep_q;
	logic [cts_pkg::IDX_W-1:0]    p_q;
	logic [cts_pkg::IDX_W-1:0]    best_pos_q;
	logic signed [31:0]           best_cd_q;
	logic                         pend_ok_q;
	logic [31:0]                  pend_aid_q;
	logic                         pend_fired_q;
	logic [31:0]                  pend_fid_q;
	logic                         add_ok_q;
	logic [31:0]                  assigned_id_q;
	logic                         fired_q;
	logic [31:0]                  fired_id_q;

	logic [cts_pkg::IDX_W-1:0]    rd_pos;
	logic [cts_pkg::IDX_W-1:0]    rd_slot;
	logic signed [31:0]           rd_cd;
	logic [cts_pkg::LEN_W-1:0]    p_ext;
	logic                         take;
	logic                         due;
	logic                         drop;
	logic                         free_found;
	logic [cts_pkg::IDX_W-1:0]    free_slot;
	logic                         add_go;

	assign rd_pos  = cmd.fire ? best_pos_q : p_q;
	assign rd_slot = order_q[rd_pos];
	assign rd_cd   = cd_q[rd_slot];
	assign p_ext   = {1'b0, p_q};
	assign take    = (p_q == '0) || (rd_cd < best_cd_q);
	assign due     = (best_cd_q <= 32'sd0);
	assign drop    = cmd.fire && due && !rep_q[rd_slot];

	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int s = cts_pkg::SLOTS - 1; s >= 0; s--) begin
			if (!valid_q[s]) begin
				free_found = 1'b1;
				free_slot  = cts_pkg::IDX_W'(s);
			end
		end
	end

	assign add_go = cmd.add && (req_period_q != '0) && free_found
		&& (len_q < cts_pkg::LEN_W'(cts_pkg::SLOTS));

	assign status.list_empty = (len_q == '0);
	assign status.scan_last  = (p_ext == len_q - cts_pkg::LEN_W'(1));

	// slot table payload
	always_ff @(posedge clk) begin
		for (int s = 0; s < cts_pkg::SLOTS; s++) begin
			if (add_go && free_slot == cts_pkg::IDX_W'(s)) begin
				cd_q[s]  <= {1'b0, req_period_q};
				per_q[s] <= req_period_q;
				rep_q[s] <= req_rep_q;
				id_q[s]  <= next_id_q;
			end else if (cmd.tick && valid_q[s] && cd_q[s] != cts_pkg::CD_FLOOR) begin
				cd_q[s] <= cd_q[s] - 32'sd1;
			end else if (cmd.fire && due && rep_q[rd_slot]
				&& rd_slot == cts_pkg::IDX_W'(s)) begin
				cd_q[s] <= {1'b0, per_q[s]};
			end
		end
	end

	// list order: append, move to front, or delete at the chosen position
	always_ff @(posedge clk) begin
		for (int p = 0; p < cts_pkg::SLOTS; p++) begin
			if (add_go && len_q == cts_pkg::LEN_W'(p)) begin
				order_q[p] <= free_slot;
			end else if (drop) begin
				if (cts_pkg::IDX_W'(p) >= best_pos_q) begin
					order_q[p] <= order_q[(p + 1) % cts_pkg::SLOTS];
				end
			end else if (cmd.fire) begin
				if (p == 0) begin
					order_q[p] <= rd_slot;
				end else if (cts_pkg::IDX_W'(p) <= best_pos_q) begin
					order_q[p] <= order_q[(p + cts_pkg::SLOTS - 1) % cts_pkg::SLOTS];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			len_q     <= '0;
			next_id_q <= '0;
			p_q       <= '0;
		end else begin
			if (add_go) begin
				valid_q[free_slot] <= 1'b1;
				len_q              <= len_q + cts_pkg::LEN_W'(1);
				next_id_q          <= next_id_q + 32'd1;
			end else if (drop) begin
				valid_q[rd_slot] <= 1'b0;
				len_q            <= len_q - cts_pkg::LEN_W'(1);
			end
			if (cmd.capture) begin
				p_q <= '0;
			end else if (cmd.scan) begin
				p_q <= p_q + cts_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_period_q <= period;
			req_rep_q    <= repeat_req;
			pend_ok_q    <= 1'b0;
			pend_aid_q   <= '0;
			pend_fired_q <= 1'b0;
			pend_fid_q   <= '0;
		end
		if (cmd.scan && take) begin
			best_pos_q <= p_q;
			best_cd_q  <= rd_cd;
		end
		if (add_go) begin
			pend_ok_q  <= 1'b1;
			pend_aid_q <= next_id_q;
		end
		if (cmd.fire && due) begin
			pend_fired_q <= 1'b1;
			pend_fid_q   <= id_q[rd_slot];
		end
		if (cmd.load_out) begin
			add_ok_q      <= pend_ok_q;
			assigned_id_q <= pend_aid_q;
			fired_q       <= pend_fired_q;
			fired_id_q    <= pend_fid_q;
		end
	end

	assign add_ok      = add_ok_q;
	assign assigned_id = assigned_id_q;
	assign fired       = fired_q;
	assign fired_id    = fired_id_q;

	`CTS_ASSERT_SAME(a_len_matches_valid, clk, arst_n, 1'b1, $countones(valid_q) == len_q)
	`CTS_ASSERT_SAME(a_scan_in_list, clk, arst_n, cmd.scan, p_ext < len_q)
	`CTS_ASSERT_SAME(a_fire_on_valid, clk, arst_n, cmd.fire && due, valid_q[rd_slot])

endmodule

// File: rtl/countdown_task_scheduler_unit.sv
// Top level of the countdown task scheduler: controller plus datapath.
// Depends on cts_pkg, cts_req_if, cts_rsp_if, cts_ctrl and cts_datapath.
//
//  channel | modport | carries
//  --------+---------+-----------------------------------------------
//  req     | sink    | request: mode, period, repeat_req
//  rsp     | source  | one response per request: add_ok, assigned_id,
//          |         | fired, fired_id
//
// Add and tick pass through their own state before the response; a run
// scans the list and then visits the chosen entry in the fire state, the
// scan reading one list entry per cycle through a single read port of the
// slot table. A run on an empty list and the unused mode go straight to the response.
// Reset clears the list length, slot valid bits, id counter and control.
// A stalled response is held in its register; the next request is taken
// meanwhile and waits for the register before its response is loaded.
module countdown_task_scheduler_unit (
	input logic     clk,
	input logic     arst_n,
	cts_req_if.sink   req,
	cts_rsp_if.source rsp
);

	cts_pkg::ctl_cmd_t   cmd;
	cts_pkg::dp_status_t status;

	cts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cts_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.period      (req.period),
		.repeat_req  (req.repeat_req),
		.add_ok      (rsp.add_ok),
		.assigned_id (rsp.assigned_id),
		.fired       (rsp.fired),
		.fired_id    (rsp.fired_id)
	);

endmodule
